### design/pfd_pkg.sv
// Package for the per-source flood detector.
// Holds the transfer structs, table entry layout and register constants.
// No dependencies.
package pfd_pkg;

  localparam int unsigned ApbAddrW = 3;

  localparam logic [15:0] ThresholdReset = 16'd100;
  localparam logic [15:0] WindowReset    = 16'd5;
  localparam logic [15:0] CountMax       = 16'hFFFF;

  localparam logic RegThreshold = 1'b0;
  localparam logic RegWindow    = 1'b1;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic [31:0] alert_address;
    logic [15:0] alert_count;
    logic        last_alert;
  } result_t;

  typedef struct packed {
    logic [15:0] alert_threshold;
    logic [15:0] window_seconds;
  } cfg_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] count;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic fresh;
    logic hit;
  } unit_res_t;

endpackage

### design/pfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfd_ram #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/pfd_cfg_regs.sv
// APB configuration registers: alert threshold and window length.
// Depends on pfd_pkg.
module pfd_cfg_regs
  import pfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegThreshold: cfg_d.alert_threshold = pwdata[15:0];
        RegWindow:    cfg_d.window_seconds  = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegThreshold: prdata = {16'd0, cfg_q.alert_threshold};
      RegWindow:    prdata = {16'd0, cfg_q.window_seconds};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alert_threshold <= ThresholdReset;
      cfg_q.window_seconds  <= WindowReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pfd_entry_unit.sv
// Shared compare unit: address match, age check and threshold check of one entry.
// Depends on pfd_pkg.
module pfd_entry_unit
  import pfd_pkg::*;
(
  input  entry_t      entry_i,
  input  logic [31:0] key_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output unit_res_t   res_o
);

  logic [31:0] age;

  assign age         = now_i - entry_i.stamp;
  assign res_o.match = (entry_i.address == key_i);
  assign res_o.fresh = (age <= {16'd0, cfg_i.window_seconds});
  assign res_o.hit   = res_o.fresh && (entry_i.count >= cfg_i.alert_threshold);

endmodule

### design/per_source_flood_detector.sv
// Top level of the per-source flood detector: sequencer, table RAM, compare unit.
// Depends on pfd_pkg, pfd_ram, pfd_entry_unit and pfd_cfg_regs.
//
//   Channel   Handshake            Payload
//   item      start / busy         item_i   (source_address, now_seconds)
//   result    result_valid_o       result_o (alert_address, alert_count, last_alert)
//   config    APB psel/penable     paddr, pwdata, prdata
//
// A packet holds busy through a scan pass and an alert/compaction pass over the N table
// entries in use before it, plus a tail step that appends its source when it is new and
// the table has room; each pass makes one RAM read port access per entry.
// The last result shows in the first cycle with busy low; the next start may transfer then.
// Reset clears the entry count and registers; table contents need no clearing.
// Results come out as one-cycle strobes; the receiver cannot stall them.
module per_source_flood_detector
  import pfd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPass,
    StTail,
    StFlush
  } state_e;

  state_e        state_q, state_d;
  item_t         item_q, item_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic [IdxW-1:0] didx_q, didx_d;
  logic          dv_q, dv_d;
  logic          found_q, found_d;
  logic [IdxW-1:0] fidx_q, fidx_d;
  logic          append_q, append_d;
  logic          pend_valid_q, pend_valid_d;
  logic [31:0]   pend_addr_q, pend_addr_d;
  logic [15:0]   pend_cnt_q, pend_cnt_d;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;

  cfg_t          cfg;
  entry_t        ram_rd;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t        ent_cur;
  unit_res_t     ures;
  logic          rd_en;
  logic          we;
  logic          scan_done;

  pfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfd_ram #(
    .Width ($bits(entry_t)),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (kept_q[IdxW-1:0]),
    .wdata_i (ent_cur),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_rd = ram_rdata;

  always_comb begin
    ent_cur = ram_rd;
    if (state_q == StTail) begin
      ent_cur.address = item_q.source_address;
      ent_cur.count   = 16'd1;
      ent_cur.stamp   = item_q.now_seconds;
    end else if (found_q && (didx_q == fidx_q) && (ram_rd.count != CountMax)) begin
      ent_cur.count = ram_rd.count + 16'd1;
    end
  end

  pfd_entry_unit u_unit (
    .entry_i (ent_cur),
    .key_i   (item_q.source_address),
    .now_i   (item_q.now_seconds),
    .cfg_i   (cfg),
    .res_o   (ures)
  );

  assign rd_en     = ((state_q == StScan) || (state_q == StPass)) && (rd_idx_q < used_q);
  assign scan_done = (rd_idx_q == used_q) && !dv_q;
  assign we        = ures.fresh && (((state_q == StPass) && dv_q) || (state_q == StTail));

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    used_d       = used_q;
    rd_idx_d     = rd_idx_q;
    kept_d       = kept_q;
    didx_d       = rd_idx_q[IdxW-1:0];
    dv_d         = rd_en;
    found_d      = found_q;
    fidx_d       = fidx_q;
    append_d     = append_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    pend_cnt_d   = pend_cnt_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    if (rd_en) begin
      rd_idx_d = rd_idx_q + CntW'(1);
    end

    if (((state_q == StPass) && dv_q) || (state_q == StTail)) begin
      if (ures.fresh) begin
        kept_d = kept_q + CntW'(1);
      end
      if (ures.hit) begin
        if (pend_valid_q) begin
          res_valid_d         = 1'b1;
          res_d.alert_address = pend_addr_q;
          res_d.alert_count   = pend_cnt_q;
          res_d.last_alert    = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_addr_d  = ent_cur.address;
        pend_cnt_d   = ent_cur.count;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d      = StScan;
          item_d       = item_i;
          rd_idx_d     = '0;
          found_d      = 1'b0;
          fidx_d       = '0;
          pend_valid_d = 1'b0;
        end
      end
      StScan: begin
        if (dv_q && ures.match && !found_q) begin
          found_d = 1'b1;
          fidx_d  = didx_q;
        end
        if (scan_done) begin
          state_d  = StPass;
          rd_idx_d = '0;
          kept_d   = '0;
          append_d = !found_q && (used_q < DepthC);
        end
      end
      StPass: begin
        if (scan_done) begin
          state_d = append_q ? StTail : StFlush;
        end
      end
      StTail: begin
        state_d = StFlush;
      end
      StFlush: begin
        used_d = kept_q;
        if (pend_valid_q) begin
          res_valid_d         = 1'b1;
          res_d.alert_address = pend_addr_q;
          res_d.alert_count   = pend_cnt_q;
          res_d.last_alert    = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      item_q       <= '0;
      used_q       <= '0;
      rd_idx_q     <= '0;
      kept_q       <= '0;
      didx_q       <= '0;
      dv_q         <= 1'b0;
      found_q      <= 1'b0;
      fidx_q       <= '0;
      append_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_addr_q  <= '0;
      pend_cnt_q   <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      used_q       <= used_d;
      rd_idx_q     <= rd_idx_d;
      kept_q       <= kept_d;
      didx_q       <= didx_d;
      dv_q         <= dv_d;
      found_q      <= found_d;
      fidx_q       <= fidx_d;
      append_q     <= append_d;
      pend_valid_q <= pend_valid_d;
      pend_addr_q  <= pend_addr_d;
      pend_cnt_q   <= pend_cnt_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
